### sv/lisl_pkg.sv
// Package for the longest increasing subsequence length block.
// Holds the transaction payload types, field widths and the sequencer state type.
// No dependencies.
package lisl_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned LenW = 11;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   first;
  } in_t;

  typedef struct packed {
    logic [LenW-1:0] length;
    logic            overflow;
  } out_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAST,
    ST_SEARCH,
    ST_RESULT
  } state_e;

endpackage

### sv/lisl_tail_ram.sv
// Tail value memory: one write port, one read port with registered read data.
// Depends on lisl_pkg for the value width.
module lisl_tail_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AddrW-1:0]               waddr_i,
  input  logic signed [lisl_pkg::ValW-1:0] wdata_i,
  input  logic                           re_i,
  input  logic [AddrW-1:0]               raddr_i,
  output logic signed [lisl_pkg::ValW-1:0] rdata_o
);
  import lisl_pkg::*;

  logic signed [ValW-1:0] mem [Depth];
  logic signed [ValW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/lisl_seq.sv
// Sequencer: run length, overflow flag and binary search over the tail memory.
// One comparator is shared by the last-tail check and every search probe.
// Depends on lisl_pkg and lisl_tail_ram.
module lisl_seq #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  lisl_pkg::in_t       item_i,
  input  logic                res_ready_i,
  output lisl_pkg::seq_stat_t stat_o,
  output lisl_pkg::out_t      result_o
);
  import lisl_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [ValW-1:0] val_q, val_d;

  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic signed [ValW-1:0] wdata, rdata;

  // Shared compare and the two candidate next probes
  logic          lt;
  logic [AW-1:0] last_idx, mid_up, lo_n, hi_n, mid_a, mid_b;

  assign lt       = rdata < val_q;
  assign last_idx = AW'(len_q - LW'(1));
  assign mid_up   = mid_q + AW'(1);
  assign lo_n     = lt ? mid_up : lo_q;
  assign hi_n     = lt ? hi_q : mid_q;
  assign mid_a    = mid_up + ((hi_q - mid_up) >> 1);
  assign mid_b    = lo_q + ((mid_q - lo_q) >> 1);

  lisl_tail_ram #(
    .Depth (MAX_LEN),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
    end
  end

  // Search bounds and held value
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    val_q <= val_d;
  end

  // Next state, memory access and result
  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    ovf_d   = ovf_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    val_d   = val_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = val_q;
    re      = 1'b0;
    raddr   = '0;
    stat_o  = '{idle: 1'b0, done: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        stat_o.idle = 1'b1;
        if (start_i) begin
          val_d = item_i.value;
          if (item_i.first || (len_q == '0)) begin
            // new sequence: table holds only this value
            we      = 1'b1;
            wdata   = item_i.value;
            len_d   = LW'(1);
            ovf_d   = 1'b0;
            state_d = ST_RESULT;
          end else begin
            re      = 1'b1;
            raddr   = last_idx;
            state_d = ST_LAST;
          end
        end
      end
      ST_LAST: begin
        if (lt) begin
          // larger than the last tail: extend, or saturate when full
          if (len_q < LW'(MAX_LEN)) begin
            we    = 1'b1;
            waddr = AW'(len_q);
            len_d = len_q + LW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          state_d = ST_RESULT;
        end else begin
          // answer lies in [0, len-1]
          lo_d = '0;
          hi_d = last_idx;
          if (last_idx == '0) begin
            we      = 1'b1;
            state_d = ST_RESULT;
          end else begin
            mid_d   = last_idx >> 1;
            re      = 1'b1;
            raddr   = last_idx >> 1;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n == hi_n) begin
          we      = 1'b1;
          waddr   = lo_n;
          state_d = ST_RESULT;
        end else begin
          mid_d = lt ? mid_a : mid_b;
          re    = 1'b1;
          raddr = lt ? mid_a : mid_b;
        end
      end
      ST_RESULT: begin
        stat_o.done = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign result_o.length   = LenW'(len_q);
  assign result_o.overflow = ovf_q;

endmodule

### sv/longest_increasing_subsequence_length_core.sv
// Longest strictly increasing subsequence length, patience method.
// Input channel: in_valid_i / in_stall_o carry one value and a first flag per
// transaction; first starts a new sequence with that value. Output channel:
// out_valid_o / out_stall_i return one result per input: the running length
// and an overflow flag that is set once the length saturates at MAX_LEN.
// One item at a time: in_stall_o is high from acceptance until the result is
// handed to the output register. A new-sequence value goes straight to the
// result state, a value that extends the table first reads the last tail, and
// a value that replaces a tail then runs a binary search. The search is paced
// by the single read port of the tail memory, which serves one binary search
// probe per cycle.
// The output register holds a finished result while the receiver stalls; the
// next item is accepted meanwhile, and its result waits until the register
// frees up. Reset clears the length and the overflow flag; the tail memory is
// not cleared, since only written entries are ever read.
// Depends on lisl_pkg and lisl_seq.
module longest_increasing_subsequence_length_core #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lisl_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lisl_pkg::out_t out_data_o
);
  import lisl_pkg::*;

  seq_stat_t stat;
  out_t      result;
  logic      res_ready, load;
  logic      out_valid_q, out_valid_d;
  out_t      out_data_q;

  assign in_stall_o = !stat.idle;
  assign res_ready  = !out_valid_q || !out_stall_i;
  assign load       = stat.done && res_ready;

  lisl_seq #(
    .MAX_LEN (MAX_LEN)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && stat.idle),
    .item_i      (in_data_i),
    .res_ready_i (res_ready),
    .stat_o      (stat),
    .result_o    (result)
  );

  // Output register
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sv/lisl_checker.sv
// Port-level checks for the longest increasing subsequence length block,
// bound to the top level. Depends on lisl_pkg.
module lisl_checker #(
  parameter int unsigned MAX_LEN = 1024
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input lisl_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input lisl_pkg::out_t out_data_o
);
  import lisl_pkg::*;

  localparam logic [LenW-1:0] MaxLenW = LenW'(MAX_LEN);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Overflow only ever comes with a saturated length
  a_ovf_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.length == MaxLenW)
    else $error("overflow reported below capacity");

  // An accepted transaction keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted back to back");

  // A new-sequence value alone yields length one once its result appears
  a_first_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.first && !out_valid_o
    |=> ##1 out_valid_o && out_data_o.length == LenW'(1) && !out_data_o.overflow)
    else $error("new sequence did not restart the length");

endmodule

bind longest_increasing_subsequence_length_core lisl_checker #(
  .MAX_LEN (MAX_LEN)
) u_lisl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### tb/sv/longest_increasing_subsequence_length_core_test.sv
// Self-checking testbench for longest_increasing_subsequence_length_core.
// Drives directed and random value streams over the valid/stall channels and
// compares every result against an in-bench patience-table predictor or a hand-written directed result. Needs lisl_pkg.
module longest_increasing_subsequence_length_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lisl_pkg::*;

  localparam int MAX_LEN     = 1024;
  localparam int WATCHDOG    = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 20;
  localparam int N_MIXED     = 200;

  // Directed row: input transaction, plus a hand-written result where obvious
  typedef struct packed {
    in_t  item;
    logic typed;
    out_t res;
  } dir_row_t;

  localparam int N_DIR = 22;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{'{32'sd5, 1'b0}, 1'b1, '{11'd1, 1'b0}},            // value before any first
    '{'{32'sd5, 1'b0}, 1'b1, '{11'd1, 1'b0}},            // equal, no extension
    '{'{32'sd7, 1'b0}, 1'b1, '{11'd2, 1'b0}},
    '{'{-32'sd3, 1'b0}, 1'b0, '0},
    '{'{32'sh7FFF_FFFF, 1'b0}, 1'b1, '{11'd3, 1'b0}},    // largest value
    '{'{32'sh7FFF_FFFF, 1'b0}, 1'b1, '{11'd3, 1'b0}},    // equal to last tail
    '{'{32'sh8000_0000, 1'b1}, 1'b1, '{11'd1, 1'b0}},    // new sequence, smallest
    '{'{32'sh7FFF_FFFF, 1'b0}, 1'b1, '{11'd2, 1'b0}},
    '{'{32'sh8000_0000, 1'b0}, 1'b1, '{11'd2, 1'b0}},    // equal to first tail
    '{'{32'sd0, 1'b0}, 1'b0, '0},
    '{'{32'sd1, 1'b0}, 1'b0, '0},
    '{'{-32'sd1, 1'b0}, 1'b0, '0},
    '{'{32'shFFFF_FFFF, 1'b1}, 1'b1, '{11'd1, 1'b0}},    // all ones
    '{'{32'sd0, 1'b0}, 1'b1, '{11'd2, 1'b0}},
    '{'{32'sh5555_5555, 1'b0}, 1'b1, '{11'd3, 1'b0}},
    '{'{32'sh2AAA_AAAA, 1'b0}, 1'b0, '0},
    '{'{32'sd100, 1'b1}, 1'b1, '{11'd1, 1'b0}},
    '{'{32'sd99, 1'b0}, 1'b1, '{11'd1, 1'b0}},
    '{'{32'sd98, 1'b0}, 1'b1, '{11'd1, 1'b0}},
    '{'{32'sd101, 1'b0}, 1'b1, '{11'd2, 1'b0}},
    '{'{32'sh7FFF_FFFE, 1'b0}, 1'b0, '0},
    '{'{32'sh8000_0000, 1'b0}, 1'b0, '0}
  };

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // Predictor state: smallest tail per length, current length, saturation
  logic signed [31:0] lis_tails [MAX_LEN];
  int                 lis_len = 0;
  logic               lis_sat = 1'b0;

  out_t len_expected_q [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_rx     = 1'b0;
  int phase       = 0;

  int errors      = 0;
  int n_items     = 0;
  int n_checked   = 0;
  int peak_len    = 0;
  int sat_seen    = 0;
  int idle_cycles = 0;

  longest_increasing_subsequence_length_core #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Patience step: restart, extend, saturate, or replace the first tail not below value
  function automatic out_t lis_predict(in_t it);
    int   lo;
    int   hi;
    int   mid;
    out_t r;
    if (it.first || lis_len == 0) begin
      lis_tails[0] = it.value;
      lis_len      = 1;
      lis_sat      = 1'b0;
    end else if ($signed(it.value) > $signed(lis_tails[lis_len-1])) begin
      if (lis_len < MAX_LEN) begin
        lis_tails[lis_len] = it.value;
        lis_len++;
      end else begin
        lis_sat = 1'b1;
      end
    end else begin
      lo = 0;
      hi = lis_len;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if ($signed(lis_tails[mid]) < $signed(it.value)) lo = mid + 1;
        else hi = mid;
      end
      if (lo < lis_len) lis_tails[lo] = it.value;
    end
    r.length   = lis_len[LenW-1:0];
    r.overflow = lis_sat;
    return r;
  endfunction

  // Offer one transaction; queue its expected result once accepted
  task automatic offer(input in_t it, input logic typed, input out_t typed_res);
    out_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pred = lis_predict(it);
    len_expected_q.insert(len_expected_q.size(), typed ? typed_res : pred);
    n_items++;
  endtask

  // Mixed random: narrow values, full-range values, rising walks, extremes
  task automatic run_mixed(input int n);
    int  v;
    int  walk;
    int  k;
    in_t it;
    walk = 0;
    repeat (n) begin
      k = $urandom_range(9);
      if (k <= 3) begin
        v = int'($urandom_range(63)) - 32;
      end else if (k <= 5) begin
        v = int'($urandom);
      end else if (k <= 8) begin
        walk += int'($urandom_range(1, 5000));
        v = walk;
      end else begin
        case ($urandom_range(3))
          0:       v = int'(32'h8000_0000);
          1:       v = int'(32'h7FFF_FFFF);
          2:       v = 0;
          default: v = -1;
        endcase
      end
      it.value = v;
      it.first = ($urandom_range(29) == 0);
      if (it.first) walk = v;
      offer(it, 1'b0, '0);
    end
  endtask

  // Long rising run that fills the table, then pushes past capacity
  task automatic run_ramp();
    int  v;
    int  extra;
    int  k;
    in_t it;
    v = int'(32'h8000_0000) + int'($urandom_range(1000));
    offer('{value: v, first: 1'b1}, 1'b0, '0);
    extra = 0;
    while (extra < 24) begin
      if (lis_len == MAX_LEN) extra++;
      k = $urandom_range(7);
      if (extra > 0 && k < 2) begin
        it.value = $urandom;
      end else if (k == 0 && lis_len > 4 && v > int'(32'h8000_0000) + (1 << 20)) begin
        // step back without wrapping below the smallest value
        it.value = v - int'($urandom_range(0, 1 << 20));
      end else begin
        v += int'($urandom_range(1, 1 << 20));
        it.value = v;
      end
      it.first = 1'b0;
      offer(it, 1'b0, '0);
    end
    // a new sequence must clear saturation
    offer('{value: $urandom, first: 1'b1}, 1'b0, '0);
  endtask

  // Result side: check accepted transactions, then choose next stall
  always @(posedge clk_i) begin
    out_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_checked++;
      if (out_data_o.length > peak_len) peak_len = out_data_o.length;
      if (out_data_o.overflow) sat_seen++;
      if (len_expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: length %0d overflow %0b",
                 $time, out_data_o.length, out_data_o.overflow);
      end else begin
        exp_res = len_expected_q.pop_front();
        if (out_data_o.length !== exp_res.length) begin
          errors++;
          $display("%0t: length expected %0d actual %0d",
                   $time, exp_res.length, out_data_o.length);
        end
        if (out_data_o.overflow !== exp_res.overflow) begin
          errors++;
          $display("%0t: overflow expected %0b actual %0b",
                   $time, exp_res.overflow, out_data_o.overflow);
        end
      end
    end
    out_stall_i <= hold_rx || ($urandom_range(99) < rx_idle_pct);
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    wait (phase == 3);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("longest_increasing_subsequence_length_core_test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles rarely, receiver often
    phase       = 1;
    tx_idle_pct = 11;
    rx_idle_pct = 87;
    for (int i = 0; i < N_DIR; i++) begin
      offer(DIR_TAB[i].item, DIR_TAB[i].typed, DIR_TAB[i].res);
    end
    run_mixed(N_MIXED);

    // swapped idling, table filled to capacity
    phase       = 2;
    tx_idle_pct = 87;
    rx_idle_pct = 11;
    run_ramp();

    // no idling, starts under the receiver hold-off
    phase       = 3;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_mixed(N_MIXED);
    in_valid_i <= 1'b0;

    while (len_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Ran %0d transactions and checked %0d results; peak length %0d,",
             n_items, n_checked, peak_len);
    $display("saturated results %0d, mismatches %0d.", sat_seen, errors);
    if (errors == 0) begin
      $display("longest_increasing_subsequence_length_core_test passed");
    end else begin
      $display("longest_increasing_subsequence_length_core_test failed");
    end
    $finish;
  end

endmodule
